// ===== design/obns_pkg.sv =====
`timescale 1ns / 1ps

package obns_pkg;

	// Table geometry
	localparam int CHUNK_SLOTS   = 256;
	localparam int NUM_CHUNKS    = 4;
	localparam int RESOURCE_BITS = 16;
	localparam int TABLE_SLOTS   = CHUNK_SLOTS * NUM_CHUNKS;

	// Field widths
	localparam int OP_W  = 3;
	localparam int KEY_W = 10;
	localparam int BIT_W = 4;

	// Storage is bit-major: one row holds SEG_SLOTS consecutive slots of one resource bit
	localparam int SEG_SLOTS = 64;
	localparam int OFF_W     = $clog2(SEG_SLOTS);
	localparam int SEG_IDX_W = KEY_W - OFF_W;
	localparam int SEGS      = TABLE_SLOTS / SEG_SLOTS;
	localparam int ROW_W     = BIT_W + SEG_IDX_W;
	localparam int ROWS      = RESOURCE_BITS * SEGS;
	localparam int CHUNK_W   = $clog2(NUM_CHUNKS);

	localparam logic [SEG_IDX_W-1:0] LAST_SEG = SEG_IDX_W'(SEGS - 1);

	// Op codes on the request channel
	localparam logic [OP_W-1:0] OP_SET        = 3'd0;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd1;
	localparam logic [OP_W-1:0] OP_TEST_SET   = 3'd2;
	localparam logic [OP_W-1:0] OP_TEST_CLEAR = 3'd3;
	localparam logic [OP_W-1:0] OP_SCAN       = 3'd4;

	// Internal command kinds
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_NOP   = 3'd0;
	localparam kind_t KIND_SET   = 3'd1;
	localparam kind_t KIND_CLEAR = 3'd2;
	localparam kind_t KIND_TSET  = 3'd3;
	localparam kind_t KIND_TCLR  = 3'd4;
	localparam kind_t KIND_SCAN  = 3'd5;

	typedef struct packed {
		kind_t                 kind;
		logic [BIT_W-1:0]      bsel;
		logic [SEG_IDX_W-1:0]  seg;
		logic [OFF_W-1:0]      off;
		logic [KEY_W-1:0]      key;
	} cmd_t;

	typedef struct packed {
		logic             answer;
		logic [KEY_W-1:0] scan_slot;
		logic             found;
	} res_t;

endpackage

// ===== design/obns_in_if.sv =====
`timescale 1ns / 1ps

interface obns_in_if;
	logic                          valid;
	logic                          ready;
	logic [obns_pkg::OP_W-1:0]     op;
	logic [obns_pkg::KEY_W-1:0]    slot_key;
	logic [obns_pkg::BIT_W-1:0]    bit_select;

	modport source (output valid, op, slot_key, bit_select, input ready);
	modport sink (input valid, op, slot_key, bit_select, output ready);
endinterface

// ===== design/obns_out_if.sv =====
`timescale 1ns / 1ps

interface obns_out_if;
	logic                          valid;
	logic                          ready;
	logic                          answer;
	logic [obns_pkg::KEY_W-1:0]    scan_slot;
	logic                          found;

	modport source (output valid, answer, scan_slot, found, input ready);
	modport sink (input valid, answer, scan_slot, found, output ready);
endinterface

// ===== design/obns_ram.sv =====
`timescale 1ns / 1ps

module obns_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd <= mem[ra];
		end
	end
endmodule

// ===== design/obns_front.sv =====
`timescale 1ns / 1ps

module obns_front (
	obns_in_if.sink          items,
	input  logic             full,
	output logic             push,
	output obns_pkg::cmd_t   cmd
);
	import obns_pkg::*;

	assign items.ready = !full;
	assign push        = items.valid && !full;

	// bit_select is 4 bits and RESOURCE_BITS is 16, so every bit index is in range
	always_comb begin
		unique case (items.op)
			OP_SET:        cmd.kind = KIND_SET;
			OP_CLEAR:      cmd.kind = KIND_CLEAR;
			OP_TEST_SET:   cmd.kind = KIND_TSET;
			OP_TEST_CLEAR: cmd.kind = KIND_TCLR;
			OP_SCAN:       cmd.kind = KIND_SCAN;
			default:       cmd.kind = KIND_NOP;
		endcase
		cmd.bsel = items.bit_select;
		cmd.seg  = items.slot_key[KEY_W-1 -: SEG_IDX_W];
		cmd.off  = items.slot_key[OFF_W-1:0];
		cmd.key  = items.slot_key;
	end
endmodule

// ===== design/obns_queue.sv =====
`timescale 1ns / 1ps

module obns_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  obns_pkg::cmd_t   wr_cmd,
	input  logic             pop,
	output obns_pkg::cmd_t   head,
	output logic             full,
	output logic             empty
);
	import obns_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	cmd_t            entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== design/obns_back.sv =====
`timescale 1ns / 1ps

module obns_back (
	input  logic             clk,
	input  logic             arst_n,
	input  obns_pkg::cmd_t   head,
	input  logic             head_valid,
	output logic             pop,
	obns_out_if.source       results
);
	import obns_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	function automatic logic [OFF_W-1:0] first_set(input logic [SEG_SLOTS-1:0] w);
		logic [OFF_W-1:0] idx;
		idx = '0;
		for (int i = SEG_SLOTS - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = OFF_W'(i);
			end
		end
		return idx;
	endfunction

	logic [1:0]             state_q;
	cmd_t                   cmd_q;
	logic [SEG_IDX_W-1:0]   rd_seg_q;
	logic [SEG_IDX_W-1:0]   ev_seg_s1;
	logic                   first_s1;
	logic [ROWS-1:0]        row_valid_q;
	logic [NUM_CHUNKS-1:0]  untouched_q;
	res_t                   res_q;
	res_t                   out_q;
	logic                   out_valid_q;

	logic                   ram_we, ram_re;
	logic [ROW_W-1:0]       ram_wa, ram_ra;
	logic [SEG_SLOTS-1:0]   ram_wd, ram_rd;

	logic [ROW_W-1:0]       row_exec, row_ev;
	logic [CHUNK_W-1:0]     chunk_exec, chunk_ev;
	logic [SEG_SLOTS-1:0]   word_exec, word_ev, low_mask, scan_word, bit_mask;
	logic                   touched_exec, bit_exec, hit, ev_last, out_free, answer_exec;
	logic [OFF_W-1:0]       hit_idx;

	obns_ram #(
		.WIDTH(SEG_SLOTS),
		.DEPTH(ROWS)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.wa(ram_wa),
		.wd(ram_wd),
		.re(ram_re),
		.ra(ram_ra),
		.rd(ram_rd)
	);

	// single-slot access
	assign row_exec     = {cmd_q.bsel, cmd_q.seg};
	assign chunk_exec   = cmd_q.seg[SEG_IDX_W-1 -: CHUNK_W];
	assign touched_exec = !untouched_q[chunk_exec];
	assign word_exec    = row_valid_q[row_exec] ? ram_rd : '0;
	assign bit_exec     = word_exec[cmd_q.off];
	assign bit_mask     = SEG_SLOTS'(1) << cmd_q.off;

	always_comb begin
		case (cmd_q.kind)
			KIND_TSET: answer_exec = touched_exec && bit_exec;
			KIND_TCLR: answer_exec = touched_exec && !bit_exec;
			default:   answer_exec = 1'b0;
		endcase
	end

	// scan: one segment evaluated per cycle, next segment read in parallel
	assign row_ev    = {cmd_q.bsel, ev_seg_s1};
	assign chunk_ev  = ev_seg_s1[SEG_IDX_W-1 -: CHUNK_W];
	assign word_ev   = (row_valid_q[row_ev] && !untouched_q[chunk_ev]) ? ram_rd : '0;
	assign low_mask  = first_s1 ? ~(bit_mask - SEG_SLOTS'(1)) : '1;
	assign scan_word = word_ev & low_mask;
	assign hit       = |scan_word;
	assign hit_idx   = first_set(scan_word);
	assign ev_last   = ev_seg_s1 == LAST_SEG;

	assign out_free  = !out_valid_q || results.ready;

	always_comb begin
		pop    = (state_q == ST_IDLE) && head_valid;
		ram_re = pop || (state_q == ST_SCAN);
		ram_ra = (state_q == ST_SCAN) ? {cmd_q.bsel, rd_seg_q} : {head.bsel, head.seg};
		ram_we = (state_q == ST_EXEC) &&
			((cmd_q.kind == KIND_SET) || (cmd_q.kind == KIND_CLEAR));
		ram_wa = row_exec;
		ram_wd = (cmd_q.kind == KIND_SET) ? (word_exec | bit_mask) : (word_exec & ~bit_mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_valid_q <= '0;
			untouched_q <= '1;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						if (head.kind == KIND_NOP) begin
							state_q <= ST_DONE;
						end else if (head.kind == KIND_SCAN) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (ram_we) begin
						row_valid_q[row_exec] <= 1'b1;
					end
					if (cmd_q.kind == KIND_SET) begin
						untouched_q[chunk_exec] <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (hit || ev_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q     <= head;
			rd_seg_q  <= head.seg + 1'b1;
			ev_seg_s1 <= head.seg;
			first_s1  <= 1'b1;
			res_q     <= '0;
		end
		if (state_q == ST_EXEC) begin
			res_q.answer    <= answer_exec;
			res_q.scan_slot <= '0;
			res_q.found     <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			rd_seg_q  <= rd_seg_q + 1'b1;
			ev_seg_s1 <= rd_seg_q;
			first_s1  <= 1'b0;
			if (hit) begin
				res_q.answer    <= 1'b0;
				res_q.scan_slot <= {ev_seg_s1, hit_idx};
				res_q.found     <= 1'b1;
			end else if (ev_last) begin
				res_q.answer    <= 1'b0;
				res_q.scan_slot <= cmd_q.key;
				res_q.found     <= 1'b0;
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_q <= res_q;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.answer    = out_q.answer;
	assign results.scan_slot = out_q.scan_slot;
	assign results.found     = out_q.found;
endmodule

// ===== design/occupancy_bitmap_next_set_scan.sv =====
`timescale 1ns / 1ps

// Occupancy bitmap: 1024 slot words of 16 resource bits, four chunks of 256 slots.
// Requests arrive on 'items' (op, slot_key, bit_select); one response per request
// leaves on 'results' (answer, scan_slot, found), in request order. Both channels
// transfer on a clock edge with valid and ready high.
// The front decodes the op and pushes a command into a two-entry queue; the back
// executes commands one at a time against a 256 x 64 RAM holding, per resource
// bit, 64 consecutive slots in each row.
// Set, clear and test pass through the back states read, modify or test, and
// hand-off. A scan reads one 64-slot row per cycle from the key's row up to the
// end of the table, stopping at the first hit.
// The queue keeps taking requests while the back works or the response waits.
// Reset (arst_n low) empties the queue and output register, marks every row as
// never written (reads as zero, no clearing pass) and every chunk as untouched.
// When the receiver holds ready low, the finished response waits in the back and
// then in the output register; requests stall once the queue fills.

module occupancy_bitmap_next_set_scan (
	input  logic        clk,
	input  logic        arst_n,
	obns_in_if.sink     items,
	obns_out_if.source  results
);
	import obns_pkg::*;

	cmd_t  cmd;      // decoded request into the queue
	cmd_t  head;     // oldest queued command
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;

	// front: handshake and op decode
	obns_front u_front (
		.items(items),
		.full(full),
		.push(push),
		.cmd(cmd)
	);

	// decoupling queue between front and back
	obns_queue #(
		.DEPTH(2)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_cmd(cmd),
		.pop(pop),
		.head(head),
		.full(full),
		.empty(empty)
	);

	// back: table access, scan walk and response register
	obns_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(!empty),
		.pop(pop),
		.results(results)
	);
endmodule

// ===== tb/obns_response_checker.sv =====
`timescale 1ns / 1ps

module obns_response_checker (
	input  logic clk,
	input  logic arst_n,
	obns_in_if   req_bus,
	obns_out_if  rsp_bus,
	output int   error_count,
	output int   outstanding
);
	import obns_pkg::*;

	// shadow of the occupancy table
	logic [RESOURCE_BITS-1:0] occ_word [TABLE_SLOTS];
	logic                     chunk_fresh [NUM_CHUNKS];

	res_t expected_responses [$];
	res_t want;
	int   mismatches = 0;
	int   pending_n = 0;

	assign error_count = mismatches;
	assign outstanding = pending_n;

	task automatic log_mismatch(input string what);
		$display("%0t ns  mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic res_t predict_response(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] key, input logic [BIT_W-1:0] bsel);
		res_t r;
		int   s;
		bit   bit_ok;
		bit   fresh;
		r = '0;
		bit_ok = (int'(bsel) < RESOURCE_BITS);
		fresh = chunk_fresh[int'(key) / CHUNK_SLOTS];
		case (op)
			OP_SET: begin
				if (bit_ok) begin
					occ_word[key][bsel] = 1'b1;
					chunk_fresh[int'(key) / CHUNK_SLOTS] = 1'b0;
				end
			end
			OP_CLEAR: begin
				// flag is left alone, even in a fresh chunk
				if (bit_ok)
					occ_word[key][bsel] = 1'b0;
			end
			OP_TEST_SET: begin
				if (bit_ok && !fresh)
					r.answer = occ_word[key][bsel];
			end
			OP_TEST_CLEAR: begin
				if (bit_ok && !fresh)
					r.answer = !occ_word[key][bsel];
			end
			OP_SCAN: begin
				// no wrap past the table end; fresh chunks never hit
				r.scan_slot = key;
				if (bit_ok) begin
					for (s = int'(key); s < TABLE_SLOTS; s++) begin
						if (!chunk_fresh[s / CHUNK_SLOTS] && occ_word[s][bsel]) begin
							r.scan_slot = KEY_W'(s);
							r.found = 1'b1;
							break;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++)
				occ_word[i] = '0;
			for (int c = 0; c < NUM_CHUNKS; c++)
				chunk_fresh[c] = 1'b1;
			expected_responses.delete();
			pending_n = 0;
		end else begin
			if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
				expected_responses.insert(expected_responses.size(),
					predict_response(req_bus.op, req_bus.slot_key, req_bus.bit_select));
			if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
				if (expected_responses.size() == 0) begin
					log_mismatch("response with no request outstanding");
				end else begin
					want = expected_responses.pop_front();
					if (rsp_bus.answer !== want.answer)
						log_mismatch($sformatf("answer %0b, predicted %0b",
							rsp_bus.answer, want.answer));
					if (rsp_bus.scan_slot !== want.scan_slot)
						log_mismatch($sformatf("scan_slot %0d, predicted %0d",
							rsp_bus.scan_slot, want.scan_slot));
					if (rsp_bus.found !== want.found)
						log_mismatch($sformatf("found %0b, predicted %0b",
							rsp_bus.found, want.found));
				end
			end
			pending_n = expected_responses.size();
		end
	end

endmodule

// ===== tb/occupancy_bitmap_next_set_scan_test.sv =====
`timescale 1ns / 1ps

module occupancy_bitmap_next_set_scan_test;
	import obns_pkg::*;

	// highest op code the 3-bit field can carry; codes above OP_SCAN do nothing
	localparam logic [OP_W-1:0] OP_TOP_CODE = 3'd7;
	// cycles with no transfer on either channel before the run is abandoned;
	// the limit is generous next to the longest honest request gap, scan and stall
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 550;
	// sets in the first random stretch stay in chunks 0 and 2
	localparam int FENCED_ITEMS = 120;
	localparam int HOT_DEPTH    = 64;

	typedef struct {
		logic [KEY_W-1:0] key;
		logic [BIT_W-1:0] bsel;
	} spot_t;

	logic clk;
	logic arst_n;
	int   error_count;
	int   outstanding;
	int   idle_cycles = 0;
	bit   req_eager = 1'b0;    // request side sends back to back while set
	bit   rsp_eager = 1'b0;    // response side holds ready high while set

	spot_t hot_spots [$];     // recently set positions, reused to hit the table

	obns_in_if  req_bus ();
	obns_out_if rsp_bus ();

	occupancy_bitmap_next_set_scan u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (req_bus),
		.results (rsp_bus)
	);

	obns_response_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_bus     (req_bus),
		.rsp_bus     (rsp_bus),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
					IDLE_LIMIT, outstanding);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// One request. Called at a falling edge; returns at the falling edge after
	// acceptance, so valid is only ever written once per time step.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [BIT_W-1:0] bsel);
		int gap;
		gap = req_eager ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.op         <= op;
		req_bus.slot_key   <= key;
		req_bus.bit_select <= bsel;
		do
			@(posedge clk);
		while (req_bus.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic note_hot(input logic [KEY_W-1:0] key, input logic [BIT_W-1:0] bsel);
		spot_t sp;
		sp.key  = key;
		sp.bsel = bsel;
		hot_spots.insert(hot_spots.size(), sp);
		if (hot_spots.size() > HOT_DEPTH)
			void'(hot_spots.pop_front());
	endtask

	// spread over the unused codes above OP_SCAN
	function automatic logic [OP_W-1:0] OP_OP_SPREAD();
		return OP_W'($urandom_range(0, OP_TOP_CODE - OP_SCAN - 1));
	endfunction

	// Random request. Half of the clears, tests and scans aim at a recently set
	// position (scans start a little below it) so that the table gets exercised
	// rather than probed where it is empty.
	task automatic random_request(input bit fenced);
		int               roll;
		int               start;
		spot_t            sp;
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [BIT_W-1:0] bsel;
		roll = $urandom_range(0, 99);
		key  = KEY_W'($urandom);
		bsel = BIT_W'($urandom);
		if (roll < 27)
			op = OP_SET;
		else if (roll < 42)
			op = OP_CLEAR;
		else if (roll < 57)
			op = OP_TEST_SET;
		else if (roll < 70)
			op = OP_TEST_CLEAR;
		else if (roll < 95)
			op = OP_SCAN;
		else
			op = OP_TOP_CODE - OP_OP_SPREAD();

		if (op == OP_SET) begin
			if (fenced)
				key[KEY_W-1 -: CHUNK_W] = ($urandom_range(0, 1) != 0) ? 2'd2 : 2'd0;
			note_hot(key, bsel);
		end else if (op <= OP_SCAN && hot_spots.size() > 0 && $urandom_range(0, 1) != 0) begin
			sp   = hot_spots[$urandom_range(0, hot_spots.size() - 1)];
			bsel = sp.bsel;
			key  = sp.key;
			if (op == OP_SCAN) begin
				start = int'(sp.key) - $urandom_range(0, 300);
				key   = KEY_W'((start < 0) ? 0 : start);
			end
		end
		send_request(op, key, bsel);
	endtask

	// Response side: one stall draw per response, with eager stretches where
	// ready stays high throughout.
	initial begin
		int stall;
		int run_left;
		rsp_bus.ready <= 1'b0;
		run_left = 40;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (run_left == 0) begin
				rsp_eager = !rsp_eager;
				run_left  = $urandom_range(20, 60);
			end
			run_left--;
			stall = rsp_eager ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do
				@(posedge clk);
			while (rsp_bus.valid !== 1'b1);
			@(negedge clk);
		end
	end

	// Request side and verdict.
	initial begin
		req_bus.valid      <= 1'b0;
		req_bus.op         <= OP_SET;
		req_bus.slot_key   <= '0;
		req_bus.bit_select <= '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: untouched chunks answer false on both tests and scans skip them
		send_request(OP_TEST_SET, 10'd0, 4'd0);
		send_request(OP_TEST_CLEAR, 10'd0, 4'd0);
		send_request(OP_SCAN, 10'd0, 4'd0);
		// clear into an untouched chunk keeps it untouched
		send_request(OP_CLEAR, 10'd300, 4'd3);
		send_request(OP_TEST_CLEAR, 10'd300, 4'd3);
		// table extremes and chunk edges
		send_request(OP_SET, 10'd0, 4'd0);
		send_request(OP_SET, 10'd1023, 4'd15);
		send_request(OP_SET, 10'd255, 4'd15);
		send_request(OP_SET, 10'd256, 4'd0);
		send_request(OP_SET, 10'd700, 4'd7);
		send_request(OP_TEST_SET, 10'd0, 4'd0);
		send_request(OP_TEST_CLEAR, 10'd0, 4'd0);
		send_request(OP_TEST_SET, 10'd1023, 4'd15);
		send_request(OP_TEST_CLEAR, 10'd1023, 4'd14);
		// scans across a chunk boundary, from the last slot and a failed one
		send_request(OP_SCAN, 10'd1, 4'd0);
		send_request(OP_SCAN, 10'd257, 4'd0);
		send_request(OP_SCAN, 10'd1023, 4'd15);
		send_request(OP_SCAN, 10'd0, 4'd15);
		send_request(OP_SCAN, 10'd600, 4'd7);
		// cleared bit in a touched chunk: the scan must not stop there
		send_request(OP_CLEAR, 10'd256, 4'd0);
		send_request(OP_SCAN, 10'd1, 4'd0);
		send_request(OP_TEST_CLEAR, 10'd256, 4'd0);
		// unused op codes with busy fields
		send_request(OP_SCAN + 3'd1, 10'd1023, 4'd15);
		send_request(OP_SCAN + 3'd2, 10'd512, 4'd8);
		send_request(OP_TOP_CODE, 10'd1, 4'd0);

		// Random part, pacing switched between eager and gappy stretches
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				req_eager = ($urandom_range(0, 2) == 0);
			random_request(n < FENCED_ITEMS);
		end
		req_bus.valid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		// anything arriving now is unexpected and caught by the checker
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
